// File: rtl/trs_pkg.sv
// Shared types, constants and helper functions for the tagged record search unit.
// No dependencies; every other file in rtl/ imports this package.
package trs_pkg;

  // Offset counters wrap at this many bits; reported offsets keep the low 32 bits
  localparam int OFFSET_BITS = 32;
  typedef logic [OFFSET_BITS-1:0] off_t;

  // Record header layout
  localparam int HEADER_BYTES = 16;
  localparam logic [3:0] POS_TAG_LAST  = 4'd6;
  localparam logic [3:0] POS_HEX_FIRST = 4'd8;
  localparam logic [3:0] POS_HEX_LAST  = 4'd14;
  localparam logic [3:0] POS_HDR_LAST  = 4'd15;

  localparam int TAG_W = 56;
  localparam int LEN_W = 28;

  // Configuration register map (register index = paddr[4:3])
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  typedef enum logic [1:0] {
    REG_SEARCH_TAG = 2'd0,
    REG_STOP_NAME  = 2'd1,
    REG_STOP_EN    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_STOP      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_TRUNC     = 2'd3
  } stat_e;

  typedef struct packed {
    logic [TAG_W-1:0] search_tag;
    logic [TAG_W-1:0] stop_name;
    logic             stop_en;
  } cfg_t;

  typedef struct packed {
    stat_e            status;
    logic [31:0]      record_offset;
    logic [31:0]      payload_offset;
    logic [LEN_W-1:0] payload_length;
  } res_t;

  // ASCII hex digit to value; anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  // Byte i of a seven-byte tag word, first byte in the low bits
  function automatic logic [7:0] tag_byte(input logic [TAG_W-1:0] w, input logic [2:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/trs_cfg_regs.sv
// APB-style configuration registers: search tag, stop name and stop name enable.
// Depends on trs_pkg for the register map and the cfg_t bundle.
module trs_cfg_regs import trs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [TAG_W-1:0] search_tag_q;
  logic [TAG_W-1:0] stop_name_q;
  logic             stop_en_q;
  reg_idx_e         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_tag_q <= '0;
      stop_name_q  <= '0;
      stop_en_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEARCH_TAG: search_tag_q <= pwdata[TAG_W-1:0];
        REG_STOP_NAME:  stop_name_q  <= pwdata[TAG_W-1:0];
        REG_STOP_EN:    stop_en_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SEARCH_TAG: prdata = PDATA_W'(search_tag_q);
      REG_STOP_NAME:  prdata = PDATA_W'(stop_name_q);
      REG_STOP_EN:    prdata = PDATA_W'(stop_en_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = '{search_tag: search_tag_q, stop_name: stop_name_q, stop_en: stop_en_q};

endmodule

// File: rtl/trs_scan.sv
// Per-byte record scanner: header position, tag and stop name compares, hex length,
// payload skip and chunk offsets. Depends on trs_pkg.
module trs_scan import trs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  cfg_t       cfg_i,
  output logic       emit_o,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       pos_q, pos_d;
  logic             tag_eq_q, tag_eq_d;
  logic             tag_end_q, tag_end_d;
  logic             name_eq_q, name_eq_d;
  logic             name_end_q, name_end_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] skip_q, skip_d;
  off_t             rec_q, rec_d;
  off_t             boff_q, boff_d;
  logic             given_q, given_d;

  off_t             rec_cur;
  off_t             pay_off;
  logic [7:0]       t_byte;
  logic [7:0]       n_byte;
  logic             tag_res;
  logic             name_res;

  assign rec_cur = (pos_q == 4'd0) ? boff_q : rec_q;
  assign pay_off = rec_cur + off_t'(HEADER_BYTES);
  assign t_byte  = tag_byte(cfg_i.search_tag, pos_q[2:0]);
  assign n_byte  = tag_byte(cfg_i.stop_name, pos_q[2:0]);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_eq_d   = tag_eq_q;
    tag_end_d  = tag_end_q;
    name_eq_d  = name_eq_q;
    name_end_d = name_end_q;
    len_d      = len_q;
    skip_d     = skip_q;
    rec_d      = rec_q;
    boff_d     = boff_q + off_t'(1);
    given_d    = given_q;
    tag_res    = 1'b0;
    name_res   = 1'b0;
    emit_o     = 1'b0;
    res_o      = '{status: ST_NOT_FOUND, record_offset: '0, payload_offset: '0,
                   payload_length: '0};

    unique case (phase_q)
      PH_HEADER: begin
        rec_d = rec_cur;
        if (pos_q <= POS_TAG_LAST) begin
          // strncmp-style compares, frozen once settled
          if (tag_eq_q && !tag_end_q) begin
            if (data_byte_i != t_byte) tag_eq_d = 1'b0;
            else if (data_byte_i == 8'd0) tag_end_d = 1'b1;
          end
          if (name_eq_q && !name_end_q) begin
            if (data_byte_i != n_byte) name_eq_d = 1'b0;
            else if (data_byte_i == 8'd0) name_end_d = 1'b1;
          end
          tag_res  = !tag_eq_d || tag_end_d || (pos_q == POS_TAG_LAST);
          name_res = !cfg_i.stop_en || !name_eq_d || name_end_d || (pos_q == POS_TAG_LAST);
          if (tag_res && name_res && !tag_eq_d && cfg_i.stop_en && name_eq_d) begin
            emit_o       = 1'b1;
            res_o.status = ST_STOP;
            phase_d      = PH_DONE;
          end
        end else if (pos_q >= POS_HEX_FIRST && pos_q <= POS_HEX_LAST) begin
          // Length digits, most significant first
          len_d = {len_q[LEN_W-5:0], hex_value(data_byte_i)};
          if (pos_q == POS_HEX_LAST && tag_eq_q) begin
            emit_o               = 1'b1;
            res_o.status         = ST_FOUND;
            res_o.record_offset  = 32'(rec_cur);
            res_o.payload_offset = 32'(pay_off);
            res_o.payload_length = len_d;
            phase_d              = PH_DONE;
          end
        end
        // Advance within the header, or move on at its end
        if (phase_d == PH_HEADER) begin
          if (pos_q == POS_HDR_LAST) begin
            pos_d      = 4'd0;
            tag_eq_d   = 1'b1;
            tag_end_d  = 1'b0;
            name_eq_d  = 1'b1;
            name_end_d = 1'b0;
            len_d      = '0;
            skip_d     = '0;
            if (len_q != '0) begin
              skip_d  = len_q;
              phase_d = PH_PAYLOAD;
            end
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        skip_d = skip_q - LEN_W'(1);
        if (skip_d == '0) begin
          phase_d    = PH_HEADER;
          pos_d      = 4'd0;
          tag_eq_d   = 1'b1;
          tag_end_d  = 1'b0;
          name_eq_d  = 1'b1;
          name_end_d = 1'b0;
          len_d      = '0;
        end
      end
      default: ;
    endcase

    // End of chunk: report if nothing was reported, then start over
    if (last_byte_i) begin
      if (!given_q && !emit_o) begin
        emit_o       = 1'b1;
        res_o.status = (phase_q == PH_HEADER && pos_q < POS_HEX_LAST) ? ST_TRUNC
                                                                       : ST_NOT_FOUND;
      end
      phase_d    = PH_HEADER;
      pos_d      = 4'd0;
      tag_eq_d   = 1'b1;
      tag_end_d  = 1'b0;
      name_eq_d  = 1'b1;
      name_end_d = 1'b0;
      len_d      = '0;
      skip_d     = '0;
      rec_d      = '0;
      boff_d     = '0;
      given_d    = 1'b0;
    end else begin
      given_d = given_q | emit_o;
    end
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= 4'd0;
      tag_eq_q   <= 1'b1;
      tag_end_q  <= 1'b0;
      name_eq_q  <= 1'b1;
      name_end_q <= 1'b0;
      len_q      <= '0;
      skip_q     <= '0;
      rec_q      <= '0;
      boff_q     <= '0;
      given_q    <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      tag_eq_q   <= tag_eq_d;
      tag_end_q  <= tag_end_d;
      name_eq_q  <= name_eq_d;
      name_end_q <= name_end_d;
      len_q      <= len_d;
      skip_q     <= skip_d;
      rec_q      <= rec_d;
      boff_q     <= boff_d;
      given_q    <= given_d;
    end
  end

endmodule

// File: rtl/tagged_record_search_unit.sv
// Tagged record search unit: input register, byte scanner, result register.
// A byte goes through the input register, the scanner and then into the result register.
// Throughput: one byte per cycle; the scanner handles each byte in a single pass, and the
// result register lets a byte in while a result waits, unless that byte makes one too.
// Reset clears the scanner, the valid flags of both beat registers and all config registers.
// Depends on trs_pkg, trs_cfg_regs and trs_scan.
module tagged_record_search_unit import trs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         search_status_o,
  output logic [31:0]        record_offset_o,
  output logic [31:0]        payload_offset_o,
  output logic [LEN_W-1:0]   payload_length_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  res_t       res_q;
  res_t       scan_res;
  logic       scan_emit;
  logic       step;

  trs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Byte moves on unless it makes a result and the result slot stays full
  assign step       = in_valid_q && (!out_valid_q || out_ready_i || !scan_emit);
  assign in_ready_o = !in_valid_q || step;

  trs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .cfg_i       (cfg),
    .emit_o      (scan_emit),
    .res_o       (scan_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && scan_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && scan_emit) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign search_status_o  = res_q.status;
  assign record_offset_o  = res_q.record_offset;
  assign payload_offset_o = res_q.payload_offset;
  assign payload_length_o = res_q.payload_length;

  // A result made by a byte that moves on is offered next cycle
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && scan_emit |=> out_valid_o)
    else $error("result beat lost");

  // A held byte stays in the input register
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("stalled byte dropped");

  // Found results carry the payload offset sixteen past the record
  a_found_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (search_status_o == ST_FOUND)
      |-> payload_offset_o == record_offset_o + 32'd16)
    else $error("payload offset mismatch");

  // Other results carry no offsets or length
  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (search_status_o != ST_FOUND)
      |-> record_offset_o == '0 && payload_offset_o == '0 && payload_length_o == '0)
    else $error("non-found result carries data");

endmodule
